@@ sv/sha256_pkg.sv @@
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;    // [0] = a ... [7] = h
  typedef logic [15:0][31:0] sched_t;  // [0] = oldest word of the window

  // in_action codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned LEN_POS = 56;  // byte where the length field starts
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ sv/sha256_stream_hasher_core.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    action, data_byte
// out_      output     out_valid/out_stall  digest_word, word_index, last_word, len_overflow
//
// The byte that completes a 64-byte block starts a compression: 64 rounds through
// the single shared round unit, then the chaining add. Finish feeds 0x80, zero and
// length bytes one per cycle around one or two such compressions. in_stall is high
// whenever the sequencer is busy; out_stall holds the current word.
// Synchronous reset restores the initial hash words, empty length and clear flag.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_len_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [60:0] TOTAL_MAX = '1;

  state_t              state_r;
  sha256_pkg::hash_t   cv_r;       // chaining value
  sha256_pkg::hash_t   v_r;        // working variables a..h
  sha256_pkg::sched_t  w_r;        // block buffer, then schedule window
  logic [5:0]          fill_r;
  logic [60:0]         total_r;
  logic                ovf_r;
  logic                fin_r;      // inside a finish sequence
  logic                len_r;      // length bytes already fed
  logic [5:0]          rnd_r;
  logic [2:0]          idx_r;

  sha256_pkg::hash_t   v_rnd;
  sha256_pkg::word_t   w_rnd;

  logic                push;
  logic [7:0]          push_byte;
  logic                wrap;
  logic [63:0]         bit_len;
  logic [2:0]          len_sel;
  logic                in_acc;
  logic                out_acc;

  sha256_round u_round (
    .v_i (v_r),
    .w_i (w_r),
    .k_i (sha256_pkg::K_TAB[rnd_r]),
    .v_o (v_rnd),
    .w_o (w_rnd)
  );

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign wrap    = (fill_r == 6'd63);
  assign bit_len = {total_r, 3'b000};
  assign len_sel = 3'd7 - fill_r[2:0];

  // Byte write into the block buffer: absorb, padding or length.
  always_comb begin
    push      = 1'b0;
    push_byte = 8'h00;
    unique case (state_r)
      ST_IDLE: begin
        push      = in_acc;
        push_byte = (in_action == sha256_pkg::ACT_FINISH) ? sha256_pkg::PAD_BYTE
                                                          : in_data_byte;
      end
      ST_PAD: begin
        push      = (fill_r != 6'(sha256_pkg::LEN_POS));
        push_byte = 8'h00;
      end
      ST_LEN: begin
        push      = 1'b1;
        push_byte = bit_len[{len_sel, 3'b000} +: 8];
      end
      default: begin
        push      = 1'b0;
        push_byte = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 8; i++) cv_r[i] <= sha256_pkg::H_INIT[i];
      fill_r  <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
      fin_r   <= 1'b0;
      len_r   <= 1'b0;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (push) begin
        for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
        w_r[15] <= {w_r[15][23:0], push_byte};
        fill_r  <= fill_r + 6'd1;
        if (wrap) begin
          v_r   <= cv_r;
          rnd_r <= '0;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_action == sha256_pkg::ACT_ABSORB) begin
              if (total_r == TOTAL_MAX) ovf_r <= 1'b1;
              else                      total_r <= total_r + 61'd1;
            end else begin
              fin_r <= 1'b1;
            end
            if (wrap)                                    state_r <= ST_RND;
            else if (in_action == sha256_pkg::ACT_FINISH) state_r <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (!push)     state_r <= ST_LEN;
          else if (wrap) state_r <= ST_RND;
        end
        ST_LEN: begin
          if (wrap) begin
            len_r   <= 1'b1;
            state_r <= ST_RND;
          end
        end
        ST_RND: begin
          v_r <= v_rnd;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_rnd;
          rnd_r   <= rnd_r + 6'd1;
          if (rnd_r == 6'(sha256_pkg::ROUNDS - 1)) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] + v_r[i];
          idx_r <= '0;
          if (!fin_r)     state_r <= ST_IDLE;
          else if (len_r) state_r <= ST_EMIT;
          else            state_r <= ST_PAD;
        end
        ST_EMIT: begin
          if (out_acc) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              // start the next message
              for (int i = 0; i < 8; i++) cv_r[i] <= sha256_pkg::H_INIT[i];
              fill_r  <= '0;
              total_r <= '0;
              ovf_r   <= 1'b0;
              fin_r   <= 1'b0;
              len_r   <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_EMIT);
  assign out_digest_word  = cv_r[idx_r];
  assign out_word_index   = idx_r;
  assign out_last_word    = (idx_r == 3'd7);
  assign out_len_overflow = ovf_r;

endmodule

@@ sv/sha256_round.sv @@
// One SHA-256 round plus the next message schedule word.
module sha256_round (
  input  sha256_pkg::hash_t  v_i,
  input  sha256_pkg::sched_t w_i,
  input  sha256_pkg::word_t  k_i,
  output sha256_pkg::hash_t  v_o,
  output sha256_pkg::word_t  w_o
);

  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;

  assign ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
  assign maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
  assign t1  = v_i[7] + sha256_pkg::big_sig1(v_i[4]) + ch + k_i + w_i[0];
  assign t2  = sha256_pkg::big_sig0(v_i[0]) + maj;

  assign v_o[0] = t1 + t2;
  assign v_o[1] = v_i[0];
  assign v_o[2] = v_i[1];
  assign v_o[3] = v_i[2];
  assign v_o[4] = v_i[3] + t1;
  assign v_o[5] = v_i[4];
  assign v_o[6] = v_i[5];
  assign v_o[7] = v_i[6];

  // w[i+16] = w[i] + s0(w[i+1]) + w[i+9] + s1(w[i+14])
  assign w_o = w_i[0] + sha256_pkg::small_sig0(w_i[1]) + w_i[9]
             + sha256_pkg::small_sig1(w_i[14]);

endmodule
